FILE: rtl/core/teq_pkg.sv
// Package of constants and codes shared by the timer event queue files.
`default_nettype none
package teq_pkg;
    localparam int QueueDepth = 16;
    localparam int TimeBits   = 48;
    localparam int TagW       = 8;
    localparam int SeqW       = 16;
    localparam int CmdW       = 3;
    localparam int KindW      = 2;
    localparam int CountW     = 5;

    localparam logic [CmdW-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CmdW-1:0] CMD_FIRE_DUE   = 3'd1;
    localparam logic [CmdW-1:0] CMD_ADVANCE    = 3'd2;
    localparam logic [CmdW-1:0] CMD_SET_TIME   = 3'd3;
    localparam logic [CmdW-1:0] CMD_CANCEL_ALL = 3'd4;
    localparam logic [CmdW-1:0] CMD_CANCEL_TAG = 3'd5;

    localparam logic [KindW-1:0] KIND_FIRED     = 2'd0;
    localparam logic [KindW-1:0] KIND_CANCELLED = 2'd1;
    localparam logic [KindW-1:0] KIND_SUMMARY   = 2'd2;
    localparam logic [KindW-1:0] KIND_REJECTED  = 2'd3;

    localparam logic [CountW-1:0] COUNT_MAX = '1;
endpackage
`default_nettype wire

FILE: rtl/core/timer_event_queue_core.sv
// Top level of the timer event queue: slot store, scan sequencer and result output.
//
// Channel   Direction  Handshake                      Payload
// command   in         start & !busy                  i_cmd i_event_tag i_event_time
//                                                     i_event_seq i_time_value
// result    out        o_result_valid, one cycle      o_result_kind o_out_tag o_out_time
//                                                     o_out_seq o_next_deadline
//                                                     o_handled_count o_was_nonempty o_last
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_data (time_mode)
//
// Every selection is one scan of the slot RAM, one slot per cycle.
// A command costs its accept and one summary scan; a drain adds one scan per event
// fired or cancelled and one more to find none left, advance one scan for the earliest
// deadline, and insert a walk of the valid bits, up to QUEUE_DEPTH slots.
// Synchronous active-low reset empties the store, sets time to zero and time_mode to 1.
// busy falls in the cycle that shows the summary item; results cannot be stalled.
`default_nettype none
module timer_event_queue_core #(
    parameter int QUEUE_DEPTH = teq_pkg::QueueDepth,
    parameter int TIME_BITS   = teq_pkg::TimeBits
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [teq_pkg::CmdW-1:0]    i_cmd,
    input  wire logic [teq_pkg::TagW-1:0]    i_event_tag,
    input  wire logic [TIME_BITS-1:0]        i_event_time,
    input  wire logic [teq_pkg::SeqW-1:0]    i_event_seq,
    input  wire logic [TIME_BITS-1:0]        i_time_value,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data,
    output logic                             o_result_valid,
    output logic [teq_pkg::KindW-1:0]        o_result_kind,
    output logic [teq_pkg::TagW-1:0]         o_out_tag,
    output logic [TIME_BITS-1:0]             o_out_time,
    output logic [teq_pkg::SeqW-1:0]         o_out_seq,
    output logic [TIME_BITS-1:0]             o_next_deadline,
    output logic [teq_pkg::CountW-1:0]       o_handled_count,
    output logic                             o_was_nonempty,
    output logic                             o_last
);
    localparam int IdxW  = $clog2(QUEUE_DEPTH);
    localparam int WordW = TIME_BITS + teq_pkg::SeqW + teq_pkg::TagW;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FREE, S_SCAN, S_WAIT, S_DECIDE
    } t_state;
    typedef enum logic [1:0] {
        PH_ADVANCE, PH_DRAIN, PH_SUMMARY
    } t_phase;
    typedef enum logic [1:0] {
        F_ANY, F_DUE, F_TAG
    } t_filter;

    t_state  r_state;
    t_phase  r_phase;
    t_filter r_filter;

    logic                         r_mode;
    logic [TIME_BITS-1:0]         r_cur;
    logic [TIME_BITS-1:0]         r_limit;
    logic [QUEUE_DEPTH-1:0]       r_valid;
    logic [IdxW-1:0]              r_idx;
    logic                         r_pv;
    logic [IdxW-1:0]              r_pidx;
    logic                         r_found;
    logic [IdxW-1:0]              r_best_idx;
    logic [TIME_BITS-1:0]         r_best_time;
    logic [teq_pkg::SeqW-1:0]     r_best_seq;
    logic [teq_pkg::TagW-1:0]     r_best_tag;
    logic [teq_pkg::TagW-1:0]     r_tag;
    logic [TIME_BITS-1:0]         r_evt_time;
    logic [teq_pkg::SeqW-1:0]     r_evt_seq;
    logic [teq_pkg::KindW-1:0]    r_kind;
    logic [teq_pkg::CountW-1:0]   r_count;
    logic                         r_is_all;

    logic                         n_we;
    logic [WordW-1:0]             n_wdata;
    logic [WordW-1:0]             n_rdata;
    logic [TIME_BITS-1:0]         n_rd_time;
    logic [teq_pkg::SeqW-1:0]     n_rd_seq;
    logic [teq_pkg::TagW-1:0]     n_rd_tag;
    logic                         n_match;
    logic                         n_better;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign n_we    = (r_state == S_FREE) && !r_valid[r_idx];
    assign n_wdata = {r_evt_time, r_evt_seq, r_tag};
    assign {n_rd_time, n_rd_seq, n_rd_tag} = n_rdata;

    teq_ram #(
        .WIDTH (WordW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_idx),
        .i_wdata (n_wdata),
        .i_raddr (r_idx),
        .o_rdata (n_rdata)
    );

    always_comb begin
        unique case (r_filter)
            F_ANY:   n_match = 1'b1;
            F_DUE:   n_match = (n_rd_time <= r_limit);
            F_TAG:   n_match = (n_rd_tag == r_tag);
            default: n_match = 1'b0;
        endcase
        n_better = r_valid[r_pidx] && n_match &&
                   (!r_found || (n_rd_time < r_best_time) ||
                    ((n_rd_time == r_best_time) && (n_rd_seq < r_best_seq)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_SUMMARY;
            r_filter       <= F_ANY;
            r_mode         <= 1'b1;
            r_cur          <= '0;
            r_valid        <= '0;
            r_pv           <= 1'b0;
            r_found        <= 1'b0;
            r_idx          <= '0;
            r_count        <= '0;
            r_is_all       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            r_pv           <= (r_state == S_SCAN);
            r_pidx         <= r_idx;

            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end

            if (r_pv && n_better) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_pidx;
                r_best_time <= n_rd_time;
                r_best_seq  <= n_rd_seq;
                r_best_tag  <= n_rd_tag;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_tag      <= i_event_tag;
                        r_evt_time <= i_event_time;
                        r_evt_seq  <= i_event_seq;
                        r_count    <= '0;
                        r_is_all   <= 1'b0;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_state    <= S_SCAN;
                        r_phase    <= PH_SUMMARY;
                        r_filter   <= F_ANY;
                        unique case (i_cmd)
                            teq_pkg::CMD_INSERT: begin
                                r_state <= S_FREE;
                            end
                            teq_pkg::CMD_FIRE_DUE: begin
                                r_phase  <= PH_DRAIN;
                                r_filter <= F_DUE;
                                r_kind   <= teq_pkg::KIND_FIRED;
                                r_limit  <= r_mode ? r_cur : i_time_value;
                            end
                            teq_pkg::CMD_ADVANCE: begin
                                if (r_mode) begin
                                    r_phase <= PH_ADVANCE;
                                end
                            end
                            teq_pkg::CMD_SET_TIME: begin
                                r_cur <= i_time_value;
                            end
                            teq_pkg::CMD_CANCEL_ALL: begin
                                r_phase  <= PH_DRAIN;
                                r_kind   <= teq_pkg::KIND_CANCELLED;
                                r_is_all <= 1'b1;
                            end
                            teq_pkg::CMD_CANCEL_TAG: begin
                                r_phase  <= PH_DRAIN;
                                r_filter <= F_TAG;
                                r_kind   <= teq_pkg::KIND_CANCELLED;
                            end
                            default: begin
                                r_phase <= PH_SUMMARY;
                            end
                        endcase
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        r_idx          <= '0;
                        r_state        <= S_SCAN;
                    end else if (r_idx == LastIdx) begin
                        o_result_valid  <= 1'b1;
                        o_result_kind   <= teq_pkg::KIND_REJECTED;
                        o_out_tag       <= r_tag;
                        o_out_time      <= r_evt_time;
                        o_out_seq       <= r_evt_seq;
                        o_next_deadline <= '0;
                        o_handled_count <= '0;
                        o_was_nonempty  <= 1'b0;
                        o_last          <= 1'b0;
                        r_idx           <= '0;
                        r_state         <= S_SCAN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LastIdx) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                    unique case (r_phase)
                        PH_ADVANCE: begin
                            if (r_found) begin
                                r_cur    <= r_best_time;
                                r_limit  <= r_best_time;
                                r_phase  <= PH_DRAIN;
                                r_filter <= F_DUE;
                                r_kind   <= teq_pkg::KIND_FIRED;
                            end else begin
                                r_phase <= PH_SUMMARY;
                            end
                        end
                        PH_DRAIN: begin
                            if (r_found) begin
                                o_result_valid      <= 1'b1;
                                o_result_kind       <= r_kind;
                                o_out_tag           <= r_best_tag;
                                o_out_time          <= r_best_time;
                                o_out_seq           <= r_best_seq;
                                o_next_deadline     <= '0;
                                o_handled_count     <= '0;
                                o_was_nonempty      <= 1'b0;
                                o_last              <= 1'b0;
                                r_valid[r_best_idx] <= 1'b0;
                                if (r_count != teq_pkg::COUNT_MAX) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end else begin
                                r_phase  <= PH_SUMMARY;
                                r_filter <= F_ANY;
                            end
                        end
                        PH_SUMMARY: begin
                            o_result_valid  <= 1'b1;
                            o_result_kind   <= teq_pkg::KIND_SUMMARY;
                            o_out_tag       <= '0;
                            o_out_time      <= '0;
                            o_out_seq       <= '0;
                            o_next_deadline <= r_found ? r_best_time : '1;
                            o_handled_count <= r_count;
                            o_was_nonempty  <= r_is_all && (r_count != '0);
                            o_last          <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/teq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
